// File: rtl/core/bitonic_table_search_defines.svh
// Assertion macros shared by the bitonic table search RTL.
`ifndef BITONIC_TABLE_SEARCH_DEFINES_SVH
`define BITONIC_TABLE_SEARCH_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define BTS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define BTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/bts_pkg.sv
// Shared constants and types for the bitonic table search.
package bts_pkg;

  // Default sizes of the table
  localparam int DEF_TABLE_DEPTH = 1024;
  localparam int DEF_VALUE_WIDTH = 32;

  // Fixed port widths
  localparam int OP_W     = 1;
  localparam int IDX_W    = 10;
  localparam int IN_VAL_W = 32;
  localparam int CNT_W    = 11;
  localparam int OUT_W    = 11;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(1);

  // Operation codes on the input channel
  localparam logic [OP_W-1:0] OP_WRITE  = 1'b0;
  localparam logic [OP_W-1:0] OP_SEARCH = 1'b1;

  // Kind of a queued job
  typedef enum logic {
    KIND_WRITE  = 1'b0,
    KIND_SEARCH = 1'b1
  } kind_t;

endpackage

// File: rtl/core/bts_front.sv
// Front end: count register, input acceptance and job classification.
module bts_front #(
  parameter int TABLE_DEPTH = bts_pkg::DEF_TABLE_DEPTH,
  parameter int VALUE_WIDTH = bts_pkg::DEF_VALUE_WIDTH,
  parameter int EW          = 1 + 3 * $clog2(TABLE_DEPTH) + VALUE_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bts_pkg::CNT_W-1:0]     element_count,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bts_pkg::OP_W-1:0]      operation,
  input  logic [bts_pkg::IDX_W-1:0]     entry_index,
  input  logic signed [bts_pkg::IN_VAL_W-1:0] item_value,
  output logic                          q_push,
  output logic [EW-1:0]                 q_entry,
  input  logic                          q_full
);
  import bts_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int NW = (AW + 1 > CNT_W) ? AW + 1 : CNT_W;

  logic [CNT_W-1:0]       count;
  logic [NW-1:0]          count_w;
  logic [NW-1:0]          n;
  logic [NW-1:0]          n_less;
  logic [NW-1:0]          idx_w;
  logic [AW-1:0]          last_idx;
  logic [AW-1:0]          midpt;
  logic [AW-1:0]          addr;
  logic [VALUE_WIDTH-1:0] value;
  logic                   idx_ok;
  logic                   accept;
  kind_t                  kind;

  // Count register, always ready for a write
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      count <= element_count;
    end
  end

  // Saturate the count to 1..TABLE_DEPTH, derive split point and last entry
  assign count_w  = NW'(count);
  assign n        = (count_w == '0) ? NW'(1) :
                    (count_w > NW'(TABLE_DEPTH)) ? NW'(TABLE_DEPTH) : count_w;
  assign n_less   = n - NW'(1);
  assign last_idx = n_less[AW-1:0];
  assign midpt    = n[AW:1];

  // Write address check
  assign idx_w  = NW'(entry_index);
  assign idx_ok = idx_w < NW'(TABLE_DEPTH);
  assign addr   = idx_w[AW-1:0];

  // Value is sign-extended or wrapped to the table width
  assign value = VALUE_WIDTH'(item_value);

  // Classify and push; out-of-range writes are dropped here
  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign kind     = (operation == OP_SEARCH) ? KIND_SEARCH : KIND_WRITE;
  assign q_push   = accept && ((kind == KIND_SEARCH) || idx_ok);
  assign q_entry  = {kind, addr, value, last_idx, midpt};

endmodule

// File: rtl/core/bts_queue.sv
// Short job queue between the front and back ends.
`include "bitonic_table_search_defines.svh"

module bts_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  output logic             valid,
  input  logic             pop,
  output logic [WIDTH-1:0] head
);
  import bts_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] slots [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    cnt;

  assign full  = (cnt == CW'(QUEUE_DEPTH));
  assign valid = (cnt != '0);
  assign head  = slots[rd_ptr];

  // Slot storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      case ({push, pop})
        2'b10:   cnt <= cnt + CW'(1);
        2'b01:   cnt <= cnt - CW'(1);
        default: cnt <= cnt;
      endcase
    end
  end

  `BTS_ASSERT_NOW(a_push_not_full, push, !full, "queue push while full")
  `BTS_ASSERT_NOW(a_pop_not_empty, pop, valid, "queue pop while empty")
  `BTS_ASSERT_NOW(a_count_bound, 1'b1, cnt <= CW'(QUEUE_DEPTH), "queue count overflow")

endmodule

// File: rtl/core/bts_back.sv
// Back end: value table, two-part binary search sequencer and result register.
`include "bitonic_table_search_defines.svh"

module bts_back #(
  parameter int TABLE_DEPTH = bts_pkg::DEF_TABLE_DEPTH,
  parameter int VALUE_WIDTH = bts_pkg::DEF_VALUE_WIDTH,
  parameter int EW          = 1 + 3 * $clog2(TABLE_DEPTH) + VALUE_WIDTH
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_valid,
  input  logic [EW-1:0]             q_head,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [bts_pkg::OUT_W-1:0] found_index
);
  import bts_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int IW = AW + 2;
  localparam int RW = (IW > OUT_W) ? IW : OUT_W;
  localparam logic signed [IW-1:0] ONE  = IW'(1);
  localparam logic signed [IW-1:0] ZERO = '0;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_CHK0   = 5'b00010,
    S_CHKEND = 5'b00100,
    S_CHKMID = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  // Job fields
  kind_t                  head_kind;
  logic [AW-1:0]          head_addr;
  logic [VALUE_WIDTH-1:0] head_value;
  logic [AW-1:0]          head_last;
  logic [AW-1:0]          head_midpt;

  assign head_kind  = kind_t'(q_head[EW-1]);
  assign head_addr  = q_head[EW-2 -: AW];
  assign head_value = q_head[EW-2-AW -: VALUE_WIDTH];
  assign head_last  = q_head[2*AW-1 -: AW];
  assign head_midpt = q_head[AW-1:0];

  // Table
  logic [VALUE_WIDTH-1:0]        mem [TABLE_DEPTH];
  logic signed [VALUE_WIDTH-1:0] rd_data;
  logic [AW-1:0]                 rd_addr;
  logic                          wr_en;

  // Sequencer state
  state_t                        state, state_next;
  logic signed [VALUE_WIDTH-1:0] key;
  logic [AW-1:0]                 last_r;
  logic [AW-1:0]                 midpt_r;
  logic signed [IW-1:0]          lo, lo_next;
  logic signed [IW-1:0]          hi, hi_next;
  logic signed [IW-1:0]          mid, mid_next;
  logic                          rising, rising_next;
  logic [OUT_W-1:0]              res;

  // Datapath helpers
  logic signed [IW-1:0] last_s;
  logic signed [IW-1:0] midpt_s;
  logic signed [IW-1:0] m_end;
  logic signed [IW-1:0] up_m;
  logic signed [IW-1:0] dn_m;
  logic                 eq;
  logic                 gt;
  logic                 go_up;
  logic                 capture;
  logic                 part_fail;
  logic                 hit;
  logic                 miss;
  logic [IW-1:0]        hit_idx;
  logic [RW-1:0]        idx_wide;
  logic                 out_free;

  assign last_s   = $signed({2'b00, last_r});
  assign midpt_s  = $signed({2'b00, midpt_r});
  assign m_end    = (lo + hi) >>> 1;
  assign up_m     = (mid + hi + ONE) >>> 1;
  assign dn_m     = (lo + mid - ONE) >>> 1;
  assign eq       = (rd_data == key);
  assign gt       = (key > rd_data);
  assign go_up    = rising ? gt : !gt;
  assign idx_wide = RW'(hit_idx);
  assign out_free = !out_valid || !out_stall;

  // Table write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[head_addr] <= head_value;
    end
    rd_data <= mem[rd_addr];
  end

  // Search sequencer: one probe per cycle, the compare picks the next address
  always_comb begin
    state_next  = state;
    lo_next     = lo;
    hi_next     = hi;
    mid_next    = mid;
    rising_next = rising;
    rd_addr     = mid[AW-1:0];
    q_pop       = 1'b0;
    wr_en       = 1'b0;
    capture     = 1'b0;
    part_fail   = 1'b0;
    hit         = 1'b0;
    miss        = 1'b0;
    hit_idx     = mid;
    case (state)
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (head_kind == KIND_WRITE) begin
            wr_en = 1'b1;
          end else begin
            capture     = 1'b1;
            lo_next     = ZERO;
            hi_next     = $signed({2'b00, head_midpt});
            rising_next = 1'b1;
            rd_addr     = '0;
            state_next  = S_CHK0;
          end
        end
      end
      S_CHK0: begin
        if (eq) begin
          hit     = 1'b1;
          hit_idx = '0;
        end else begin
          rd_addr    = hi[AW-1:0];
          state_next = S_CHKEND;
        end
      end
      S_CHKEND: begin
        if (eq) begin
          hit     = 1'b1;
          hit_idx = hi;
        end else if (lo <= hi) begin
          rd_addr    = m_end[AW-1:0];
          mid_next   = m_end;
          state_next = S_CHKMID;
        end else begin
          part_fail = 1'b1;
        end
      end
      S_CHKMID: begin
        if (eq) begin
          hit     = 1'b1;
          hit_idx = mid;
        end else if (go_up) begin
          lo_next = mid + ONE;
          if (mid < hi) begin
            rd_addr  = up_m[AW-1:0];
            mid_next = up_m;
          end else begin
            part_fail = 1'b1;
          end
        end else begin
          hi_next = mid - ONE;
          if (lo < mid) begin
            rd_addr  = dn_m[AW-1:0];
            mid_next = dn_m;
          end else begin
            part_fail = 1'b1;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // Rising part exhausted: move to the falling part, else report a miss
    if (part_fail) begin
      if (rising) begin
        rising_next = 1'b0;
        lo_next     = midpt_s + ONE;
        hi_next     = last_s;
        rd_addr     = last_r;
        state_next  = S_CHKEND;
      end else begin
        miss = 1'b1;
      end
    end
    if (hit || miss) begin
      state_next = S_DONE;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Search registers
  always_ff @(posedge clk) begin
    lo     <= lo_next;
    hi     <= hi_next;
    mid    <= mid_next;
    rising <= rising_next;
    if (capture) begin
      key     <= head_value;
      last_r  <= head_last;
      midpt_r <= head_midpt;
    end
    if (hit || miss) begin
      res <= hit ? idx_wide[OUT_W-1:0] : '1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && out_free) begin
      found_index <= res;
    end
  end

  `BTS_ASSERT_NOW(a_mid_in_segment, state == S_CHKMID, (lo <= mid) && (mid <= hi),
    "midpoint probe outside its segment")
  `BTS_ASSERT_NOW(a_end_in_table, state == S_CHKEND, (hi >= ZERO) && (hi <= last_s),
    "segment end outside the used table")
  `BTS_ASSERT_NEXT(a_result_lands, (state == S_DONE) && !out_valid, out_valid,
    "finished search did not reach the output register")

endmodule

// File: rtl/core/bitonic_table_search.sv
// Top level of the bitonic table search.
// A table of TABLE_DEPTH signed values; entries 0..count/2 rise and the rest fall.
// A write item stores one value and returns no result. A search item
// probes entry 0, then binary-searches the rising part and then the falling part,
// each starting at its segment end, and returns the hit index or -1. The table
// has one registered read port and the sequencer issues one probe per cycle; a
// search pops its job, probes entry 0, the rising segment end and its midpoints,
// then the falling segment end and its midpoints, and hands the result to the
// output register. A two-entry queue separates input acceptance from the search
// engine, and the result sits in an output register while the next job runs. The
// count register resets to 1; the table holds no reset value and must be written
// before use.
module bitonic_table_search #(
  parameter int TABLE_DEPTH = bts_pkg::DEF_TABLE_DEPTH,
  parameter int VALUE_WIDTH = bts_pkg::DEF_VALUE_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bts_pkg::CNT_W-1:0]           element_count,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [bts_pkg::OP_W-1:0]            operation,
  input  logic [bts_pkg::IDX_W-1:0]           entry_index,
  input  logic signed [bts_pkg::IN_VAL_W-1:0] item_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [bts_pkg::OUT_W-1:0]    found_index
);
  import bts_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int EW = 1 + 3 * AW + VALUE_WIDTH;

  logic          q_push;
  logic [EW-1:0] q_entry;
  logic          q_full;
  logic          q_valid;
  logic          q_pop;
  logic [EW-1:0] q_head;
  logic [OUT_W-1:0] found_bits;

  assign found_index = $signed(found_bits);

  bts_front #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH),
    .EW          (EW)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .element_count (element_count),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .operation     (operation),
    .entry_index   (entry_index),
    .item_value    (item_value),
    .q_push        (q_push),
    .q_entry       (q_entry),
    .q_full        (q_full)
  );

  bts_queue #(
    .WIDTH (EW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_entry),
    .full      (q_full),
    .valid     (q_valid),
    .pop       (q_pop),
    .head      (q_head)
  );

  bts_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH),
    .EW          (EW)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .found_index (found_bits)
  );

endmodule
